FILE: rtl/ugcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ugcc_pkg
// Shared types, codes and lookup tables of the UTF-8 glyph code classifier.
// ----------------------------------------------------------------------------
package ugcc_pkg;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_LEAD = 2'd1;
   localparam logic [1:0] STATUS_END      = 2'd2;

   localparam logic [2:0] MAX_SIZE_INDEX = 3'd6;
   localparam int         FONT_ROWS      = 14;
   localparam logic [3:0] LAST_ROW       = 4'(FONT_ROWS - 1);

   localparam logic [15:0] KANA_FIRST  = 16'hFF61;
   localparam logic [15:0] KANA_LAST   = 16'hFF9F;
   localparam logic [15:0] WIDE_FIRST  = 16'h3000;

   typedef struct packed {
      logic [15:0] code;
      logic [1:0]  len;
      logic [1:0]  status;
   } q_entry_type;

   typedef struct packed {
      logic [4:0] w;
      logic [4:0] h;
      logic [6:0] nbytes;
   } font_geom_type;

   localparam font_geom_type GEOM_TAB [0:FONT_ROWS-1] = '{
      '{5'd4,  5'd8,  7'd8 }, '{5'd5,  5'd10, 7'd10}, '{5'd6,  5'd12, 7'd12},
      '{5'd7,  5'd14, 7'd14}, '{5'd8,  5'd16, 7'd16}, '{5'd10, 5'd20, 7'd40},
      '{5'd12, 5'd24, 7'd48}, '{5'd8,  5'd8,  7'd8 }, '{5'd10, 5'd10, 7'd20},
      '{5'd12, 5'd12, 7'd24}, '{5'd14, 5'd14, 7'd28}, '{5'd16, 5'd16, 7'd32},
      '{5'd20, 5'd20, 7'd60}, '{5'd24, 5'd24, 7'd72}
   };

   localparam logic [7:0] KANA_TAB [0:62] = '{
      8'h02,8'h0C,8'h0D,8'h01,8'hFB,8'hF2,8'hA1,8'hA3,
      8'hA5,8'hA7,8'hA9,8'hE3,8'hE5,8'hE7,8'hC3,8'hFD,
      8'hA2,8'hA4,8'hA6,8'hA8,8'hAA,8'hAB,8'hAD,8'hAF,
      8'hB1,8'hB3,8'hB5,8'hB7,8'hB9,8'hBB,8'hBD,8'hBF,
      8'hC1,8'hC4,8'hC6,8'hC8,8'hCA,8'hCB,8'hCC,8'hCD,
      8'hCE,8'hCF,8'hD2,8'hD5,8'hD8,8'hDB,8'hDE,8'hDF,
      8'hE0,8'hE1,8'hE2,8'hE4,8'hE6,8'hE8,8'hE9,8'hEA,
      8'hEB,8'hEC,8'hED,8'hEF,8'hF3,8'h9B,8'h9C
   };

   function automatic logic is_wide_latin(input logic [15:0] c);
      logic r;
      unique case (c)
         16'h005C, 16'h00A2, 16'h00A3, 16'h00A7,
         16'h00A8, 16'h00AC, 16'h00B0, 16'h00B1,
         16'h00B4, 16'h00B6, 16'h00D7, 16'h00F7: r = 1'b1;
         default:                                r = 1'b0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/ugcc_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ugcc_req_if
// Byte input channel: valid/ready handshake carrying one text byte.
// ----------------------------------------------------------------------------
interface ugcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/ugcc_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ugcc_rsp_if
// Result channel: valid/ready handshake carrying one classified code.
// ----------------------------------------------------------------------------
interface ugcc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] char_code;
   logic        full_width;
   logic [3:0]  font_number;
   logic [4:0]  glyph_width;
   logic [4:0]  glyph_height;
   logic [6:0]  glyph_bytes;
   logic [1:0]  seq_length;
   logic [1:0]  status;

   modport source (output valid, output char_code, output full_width,
                   output font_number, output glyph_width, output glyph_height,
                   output glyph_bytes, output seq_length, output status,
                   input ready);
   modport sink   (input valid, input char_code, input full_width,
                   input font_number, input glyph_width, input glyph_height,
                   input glyph_bytes, input seq_length, input status,
                   output ready);
endinterface
`default_nettype wire

FILE: rtl/utf8_glyph_code_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_glyph_code_classifier
// Top level: UTF-8 byte stream in, classified glyph codes with font geometry
// out.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle and gives at most one result per
// byte, one per cycle sustained while results are taken. The assembler turns
// a byte into a queue entry in the cycle it is accepted; the classifier takes
// the queue head into its output register once that register is free or is
// being taken. A QUEUE_DEPTH-entry queue between the two lets the input keep
// flowing while the result side stalls; the input stalls only when that queue
// is full. size_index saturates at 6 when written.
module utf8_glyph_code_classifier
   import ugcc_pkg::*;
#(
   parameter int FULL_OFFSET = 7,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_wr_data,
   ugcc_req_if.sink         req_chan,
   ugcc_rsp_if.source       rsp_chan
);

   logic [2:0]  size_ff;
   logic        q_full, q_not_empty, push, pop;
   q_entry_type push_entry, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= 3'd0;
      end else if (csr_wr_en) begin
         size_ff <= (csr_wr_data > MAX_SIZE_INDEX) ? MAX_SIZE_INDEX : csr_wr_data;
      end
   end

   ugcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_chan.valid),
      .text_byte  (req_chan.text_byte),
      .q_full     (q_full),
      .byte_ready (req_chan.ready),
      .push       (push),
      .push_entry (push_entry)
   );

   ugcc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (head)
   );

   ugcc_back #(.FULL_OFFSET(FULL_OFFSET)) u_back (
      .clock      (clock),
      .reset      (reset),
      .size_index (size_ff),
      .head_valid (q_not_empty),
      .head       (head),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule
`default_nettype wire

FILE: rtl/ugcc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ugcc_front
// Sequence assembler: gathers UTF-8 bytes into codes, flags bad leads and
// end of string, and pushes one queue entry per finished sequence.
// ----------------------------------------------------------------------------
module ugcc_front
   import ugcc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        byte_valid,
   input  wire logic [7:0]  text_byte,
   input  wire logic        q_full,
   output logic             byte_ready,
   output logic             push,
   output q_entry_type      push_entry
);

   logic [1:0] pend_ff, pend_in;
   logic [9:0] part_ff, part_in;
   logic [1:0] total_ff, total_in;
   logic       take;
   logic       emit;
   logic [5:0] low6;

   assign byte_ready = !q_full;
   assign take       = byte_valid && byte_ready;
   assign low6       = text_byte[5:0];
   assign push       = take && emit;

   always_comb begin
      pend_in    = pend_ff;
      part_in    = part_ff;
      total_in   = total_ff;
      emit       = 1'b0;
      push_entry = '{code: 16'd0, len: 2'd0, status: STATUS_OK};
      priority if (text_byte == 8'd0) begin
         pend_in = 2'd0; part_in = 10'd0; total_in = 2'd0;
         emit = 1'b1;
         push_entry.status = STATUS_END;
      end else if (pend_ff == 2'd1) begin
         pend_in = 2'd0; part_in = 10'd0; total_in = 2'd0;
         emit = 1'b1;
         push_entry.code = {part_ff, low6};
         push_entry.len  = total_ff;
      end else if (pend_ff == 2'd2) begin
         pend_in = 2'd1;
         part_in = {part_ff[3:0], low6};
      end else if (!text_byte[7]) begin
         emit = 1'b1;
         push_entry.code = {8'd0, text_byte};
         push_entry.len  = 2'd1;
      end else if (text_byte[7:5] == 3'b110) begin
         pend_in = 2'd1; part_in = {5'd0, text_byte[4:0]}; total_in = 2'd2;
      end else if (text_byte[7:4] == 4'b1110) begin
         pend_in = 2'd2; part_in = {6'd0, text_byte[3:0]}; total_in = 2'd3;
      end else begin
         pend_in = 2'd0; part_in = 10'd0; total_in = 2'd0;
         emit = 1'b1;
         push_entry.status = STATUS_BAD_LEAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 2'd0;
         part_ff  <= 10'd0;
         total_ff <= 2'd0;
      end else if (take) begin
         pend_ff  <= pend_in;
         part_ff  <= part_in;
         total_ff <= total_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/ugcc_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ugcc_fifo
// Small register queue between the assembler and the classifier.
// ----------------------------------------------------------------------------
module ugcc_fifo
   import ugcc_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire q_entry_type  push_entry,
   input  wire logic         pop,
   output logic              full,
   output logic              not_empty,
   output q_entry_type       head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   q_entry_type         mem_ff [0:DEPTH-1];
   logic [AW-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]         count_ff;

   assign full      = (count_ff == (AW+1)'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: rtl/ugcc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ugcc_back
// Classifier: substitutions, width class, kana remap and font geometry,
// registered into the result channel.
// ----------------------------------------------------------------------------
module ugcc_back
   import ugcc_pkg::*;
#(
   parameter int FULL_OFFSET = 7
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [2:0]  size_index,
   input  wire logic        head_valid,
   input  wire q_entry_type head,
   output logic             pop,
   ugcc_rsp_if.source       rsp
);

   logic        valid_ff;
   logic [15:0] code_ff, code_in;
   logic        full_ff, full_in;
   logic [3:0]  row_ff, row_in;
   logic [4:0]  w_ff, h_ff;
   logic [6:0]  nb_ff;
   logic [1:0]  len_ff, status_ff;
   logic [15:0] sub_code;
   logic [4:0]  row_sum;
   logic        is_ok;
   font_geom_type geom;

   assign pop   = head_valid && (!valid_ff || rsp.ready);
   assign is_ok = (head.status == STATUS_OK);

   always_comb begin
      unique case (head.code)
         16'hFF3C: sub_code = 16'h005C;
         16'hFFE0: sub_code = 16'h00A2;
         16'hFFE1: sub_code = 16'h00A3;
         16'hFFE2: sub_code = 16'h00AC;
         default:  sub_code = head.code;
      endcase
      code_in = sub_code;
      if (sub_code < WIDE_FIRST) begin
         full_in = is_wide_latin(sub_code);
      end else begin
         full_in = 1'b1;
         if (sub_code >= KANA_FIRST && sub_code <= KANA_LAST) begin
            code_in = WIDE_FIRST + {8'd0, KANA_TAB[6'(sub_code - KANA_FIRST)]};
         end
      end
      row_sum = {2'd0, size_index} + (full_in ? 5'(FULL_OFFSET) : 5'd0);
      row_in  = (row_sum > {1'b0, LAST_ROW}) ? LAST_ROW : row_sum[3:0];
      geom    = GEOM_TAB[row_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         code_ff   <= is_ok ? code_in : 16'd0;
         full_ff   <= is_ok && full_in;
         row_ff    <= is_ok ? row_in : 4'd0;
         w_ff      <= is_ok ? geom.w : 5'd0;
         h_ff      <= is_ok ? geom.h : 5'd0;
         nb_ff     <= is_ok ? geom.nbytes : 7'd0;
         len_ff    <= is_ok ? head.len : 2'd0;
         status_ff <= head.status;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.char_code    = code_ff;
   assign rsp.full_width   = full_ff;
   assign rsp.font_number  = row_ff;
   assign rsp.glyph_width  = w_ff;
   assign rsp.glyph_height = h_ff;
   assign rsp.glyph_bytes  = nb_ff;
   assign rsp.seq_length   = len_ff;
   assign rsp.status       = status_ff;

endmodule
`default_nettype wire

FILE: tb/sv/ugcc_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugcc_tb_pkg
// Result type, font tables and the result scoreboard for the UTF-8 glyph code
// classifier testbench. The scoreboard follows the byte stream, assembles
// codes, classifies them and keeps the results still due from the block.
// ----------------------------------------------------------------------------
package ugcc_tb_pkg;
   import ugcc_pkg::*;

   typedef struct packed {
      logic [15:0] char_code;
      logic        full_width;
      logic [3:0]  font_number;
      logic [4:0]  glyph_width;
      logic [4:0]  glyph_height;
      logic [6:0]  glyph_bytes;
      logic [1:0]  seq_length;
      logic [1:0]  status;
   } glyph_result_type;

   localparam logic [3:0] WIDE_ROW_OFFSET = 4'd7;
   localparam logic [3:0] LAST_FONT_ROW   = 4'd13;

   localparam logic [4:0] FONT_W [14] = '{
      4, 5, 6, 7, 8, 10, 12, 8, 10, 12, 14, 16, 20, 24};
   localparam logic [4:0] FONT_H [14] = '{
      8, 10, 12, 14, 16, 20, 24, 8, 10, 12, 14, 16, 20, 24};
   localparam logic [6:0] FONT_BYTES [14] = '{
      8, 10, 12, 14, 16, 40, 48, 8, 20, 24, 28, 32, 60, 72};

   // low byte of the full-width code for each half-width kana code
   localparam logic [7:0] KATAKANA_LOW [63] = '{
      8'h02, 8'h0C, 8'h0D, 8'h01, 8'hFB, 8'hF2, 8'hA1, 8'hA3,
      8'hA5, 8'hA7, 8'hA9, 8'hE3, 8'hE5, 8'hE7, 8'hC3, 8'hFD,
      8'hA2, 8'hA4, 8'hA6, 8'hA8, 8'hAA, 8'hAB, 8'hAD, 8'hAF,
      8'hB1, 8'hB3, 8'hB5, 8'hB7, 8'hB9, 8'hBB, 8'hBD, 8'hBF,
      8'hC1, 8'hC4, 8'hC6, 8'hC8, 8'hCA, 8'hCB, 8'hCC, 8'hCD,
      8'hCE, 8'hCF, 8'hD2, 8'hD5, 8'hD8, 8'hDB, 8'hDE, 8'hDF,
      8'hE0, 8'hE1, 8'hE2, 8'hE4, 8'hE6, 8'hE8, 8'hE9, 8'hEA,
      8'hEB, 8'hEC, 8'hED, 8'hEF, 8'hF3, 8'h9B, 8'h9C};

   // codes worth hitting often: wide latin, substitutions, kana edges
   localparam logic [15:0] NOTABLE_CODES [29] = '{
      16'h005C, 16'h00A2, 16'h00A3, 16'h00A7, 16'h00A8, 16'h00AC,
      16'h00B0, 16'h00B1, 16'h00B4, 16'h00B6, 16'h00D7, 16'h00F7,
      16'h00A1, 16'h00A4, 16'h007F, 16'h0080, 16'h00FF, 16'hFF3C,
      16'hFFE0, 16'hFFE1, 16'hFFE2, 16'hFF60, 16'hFF61, 16'hFF9F,
      16'hFFA0, 16'h2FFF, 16'h3000, 16'hFFFF, 16'h0000};

   class glyph_scoreboard;
      glyph_result_type expected[$];
      logic [2:0]    size_sel;
      logic [1:0]    bytes_left;
      logic [9:0]    code_bits;
      logic [1:0]    seq_bytes;
      int            errors;

      function new();
         expected.delete();
         size_sel = '0;
         errors = 0;
         clear_sequence();
      endfunction

      function void clear_sequence();
         bytes_left = '0;
         code_bits = '0;
         seq_bytes = '0;
      endfunction

      function void set_size(logic [2:0] value);
         size_sel = (value > MAX_SIZE_INDEX) ? MAX_SIZE_INDEX : value;
      endfunction

      function int outstanding();
         return expected.size();
      endfunction

      function glyph_result_type flag_result(logic [1:0] st);
         glyph_result_type r;
         r = '0;
         r.status = st;
         return r;
      endfunction

      function glyph_result_type classify(logic [15:0] raw, logic [1:0] len);
         glyph_result_type r;
         logic [15:0] c;
         logic        wide;
         logic [3:0]  row;
         case (raw)
            16'hFF3C: c = 16'h005C;
            16'hFFE0: c = 16'h00A2;
            16'hFFE1: c = 16'h00A3;
            16'hFFE2: c = 16'h00AC;
            default:  c = raw;
         endcase
         if (c < WIDE_FIRST) begin
            wide = c inside {16'h005C, 16'h00A2, 16'h00A3, 16'h00A7, 16'h00A8,
                             16'h00AC, 16'h00B0, 16'h00B1, 16'h00B4, 16'h00B6,
                             16'h00D7, 16'h00F7};
         end else begin
            wide = 1'b1;
            if (c >= KANA_FIRST && c <= KANA_LAST) begin
               c = WIDE_FIRST + {8'h00, KATAKANA_LOW[int'(c - KANA_FIRST)]};
            end
         end
         row = {1'b0, size_sel} + (wide ? WIDE_ROW_OFFSET : 4'd0);
         if (row > LAST_FONT_ROW) begin
            row = LAST_FONT_ROW;
         end
         r.char_code    = c;
         r.full_width   = wide;
         r.font_number  = row;
         r.glyph_width  = FONT_W[row];
         r.glyph_height = FONT_H[row];
         r.glyph_bytes  = FONT_BYTES[row];
         r.seq_length   = len;
         r.status       = STATUS_OK;
         return r;
      endfunction

      // one accepted byte; queues the result it finishes, if any
      function void note_byte(logic [7:0] b);
         logic [15:0] code;
         if (b == 8'h00) begin
            clear_sequence();
            expected.push_back(flag_result(STATUS_END));
         end else if (bytes_left == 2'd1) begin
            code = {code_bits, b[5:0]};
            expected.push_back(classify(code, seq_bytes));
            clear_sequence();
         end else if (bytes_left == 2'd2) begin
            code_bits = {code_bits[3:0], b[5:0]};
            bytes_left = 2'd1;
         end else if (b < 8'h80) begin
            expected.push_back(classify({8'h00, b}, 2'd1));
         end else if (b >= 8'hC0 && b < 8'hE0) begin
            code_bits = {5'd0, b[4:0]};
            bytes_left = 2'd1;
            seq_bytes = 2'd2;
         end else if (b >= 8'hE0 && b < 8'hF0) begin
            code_bits = {6'd0, b[3:0]};
            bytes_left = 2'd2;
            seq_bytes = 2'd3;
         end else begin
            clear_sequence();
            expected.push_back(flag_result(STATUS_BAD_LEAD));
         end
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40) begin
            $display("ERROR at %0t: %s", $time, msg);
         end
      endtask

      task check_field(string name, int got, int want);
         if (got != want) begin
            report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
         end
      endtask

      task check_result(glyph_result_type got);
         glyph_result_type want;
         if (expected.size() == 0) begin
            report($sformatf("unexpected result, code 0x%0h status %0d",
                             got.char_code, got.status));
         end else begin
            want = expected.pop_front();
            check_field("char_code", got.char_code, want.char_code);
            check_field("full_width", got.full_width, want.full_width);
            check_field("font_number", got.font_number, want.font_number);
            check_field("glyph_width", got.glyph_width, want.glyph_width);
            check_field("glyph_height", got.glyph_height, want.glyph_height);
            check_field("glyph_bytes", got.glyph_bytes, want.glyph_bytes);
            check_field("seq_length", got.seq_length, want.seq_length);
            check_field("status", got.status, want.status);
         end
      endtask
   endclass

endpackage

FILE: tb/sv/utf8_glyph_code_classifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_glyph_code_classifier_tb
// Drives UTF-8 byte streams into the classifier and checks every result
// against an in-bench prediction. A directed pass covers field extremes and
// corner cases; random passes then run mostly well-formed sequences plus
// noise, across several font sizes and handshake idle/stall patterns,
// including one long result hold-off that backs up the input.
// ----------------------------------------------------------------------------
module utf8_glyph_code_classifier_tb;
   import ugcc_pkg::*;
   import ugcc_tb_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_WAIT  = 6;
   localparam int HOLD_CYCLES  = 60;
   localparam int PHASE_BYTES  = 205;

   localparam logic [7:0] DIRECTED_BYTES [24] = '{
      8'h00, 8'h41, 8'h80, 8'hFF, 8'hF0, 8'h5C,
      8'hC2, 8'hA2,
      8'hDF, 8'hBF,
      8'hE3, 8'h80, 8'h80,
      8'hEF, 8'hBC, 8'hBC,
      8'hEF, 8'hBD, 8'hA1,
      8'hE3, 8'h00,
      8'hE0, 8'hFF, 8'hC0};

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [2:0] csr_wr_data;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_request = 1'b0;
   int cycle_count = 0;

   glyph_scoreboard sb = new();

   ugcc_req_if req_chan ();
   ugcc_rsp_if rsp_chan ();

   utf8_glyph_code_classifier dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            sb.note_byte(req_chan.text_byte);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            sb.check_result({rsp_chan.char_code, rsp_chan.full_width,
                             rsp_chan.font_number, rsp_chan.glyph_width,
                             rsp_chan.glyph_height, rsp_chan.glyph_bytes,
                             rsp_chan.seq_length, rsp_chan.status});
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("utf8_glyph_code_classifier_tb: done, errors");
      $finish;
   end

   // result side; a hold-off request keeps ready low for a long stretch
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic logic [7:0] tail_byte(logic [5:0] low6);
      logic [7:0] b;
      b = {2'($urandom_range(3)), low6};
      return (b == 8'h00) ? 8'h80 : b;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.text_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_size(input logic [2:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_size(value);
   endtask

   task automatic send_sequence(inout int sent);
      logic [7:0]  seq[$];
      logic [15:0] code;
      int          pick;
      int          sel;
      pick = $urandom_range(99);
      if (pick < 20) begin
         seq.push_back(8'($urandom_range(127, 1)));
      end else if (pick < 45) begin
         if ($urandom_range(1) == 1) begin
            code = 16'($urandom_range(16'h07FF));
         end else begin
            code = NOTABLE_CODES[$urandom_range(28)] & 16'h07FF;
         end
         seq.push_back({3'b110, code[10:6]});
         seq.push_back(tail_byte(code[5:0]));
      end else if (pick < 80) begin
         sel = $urandom_range(9);
         if (sel < 4) begin
            code = 16'($urandom_range(16'hFFFF));
         end else if (sel < 7) begin
            code = NOTABLE_CODES[$urandom_range(28)];
         end else begin
            code = KANA_FIRST + 16'($urandom_range(62));
         end
         seq.push_back({4'b1110, code[15:12]});
         seq.push_back(tail_byte(code[11:6]));
         seq.push_back(tail_byte(code[5:0]));
      end else if (pick < 88) begin
         seq.push_back(8'h00);
      end else if (pick < 96) begin
         seq.push_back(8'($urandom_range(255)));
      end else begin
         // truncated sequence cut by an end byte or random noise
         seq.push_back(8'($urandom_range(8'hEF, 8'hC0)));
         if ($urandom_range(1) == 1) begin
            seq.push_back(tail_byte(6'($urandom_range(63))));
         end
         seq.push_back(($urandom_range(1) == 1) ? 8'h00 : 8'($urandom_range(255)));
      end
      foreach (seq[i]) begin
         send_byte(seq[i]);
      end
      sent += seq.size();
   endtask

   task automatic run_phase(input logic [2:0] size, input int send_pct,
                            input int recv_pct, input bit pressure);
      int sent;
      sent = 0;
      write_size(size);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      if (pressure) begin
         hold_request = 1'b1;
      end
      while (sent < PHASE_BYTES) begin
         send_sequence(sent);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.text_byte = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_size(3'd0);
      foreach (DIRECTED_BYTES[i]) begin
         send_byte(DIRECTED_BYTES[i]);
      end

      run_phase(3'd6, 0, 0, 1'b1);
      run_phase(3'd7, 87, 0, 1'b0);
      run_phase(3'd3, 0, 87, 1'b0);
      run_phase(3'd0, 20, 20, 1'b0);
      run_phase(3'd1, 0, 0, 1'b0);
      wait_idle();

      if (sb.errors == 0) begin
         $display("utf8_glyph_code_classifier_tb: done, clean");
      end else begin
         $display("utf8_glyph_code_classifier_tb: done, errors");
      end
      $finish;
   end

endmodule
